>>> rtl/rdc_pkg.sv
// Shared constants, types and the digit glyph function for the radix digit converter.
`timescale 1ns / 1ps
package rdc_pkg;

   localparam int VALUE_BITS  = 32;
   localparam int RADIX_BITS  = 5;
   localparam int CHAR_BITS   = 7;
   localparam int DIGIT_BITS  = 4;
   localparam int REM_BITS    = DIGIT_BITS + 1;
   localparam int DIV_BITS    = VALUE_BITS - 1;
   localparam int DIGIT_DEPTH = VALUE_BITS - 1;
   localparam int STEP_BITS   = $clog2(DIV_BITS);
   localparam int LEVEL_BITS  = $clog2(DIGIT_DEPTH + 1);
   localparam int INDEX_BITS  = $clog2(DIGIT_DEPTH);
   localparam int REQ_DATA_W  = ((VALUE_BITS + RADIX_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_W  = ((CHAR_BITS + 7) / 8) * 8;
   localparam int RSP_USER_W  = 2;

   localparam logic [RADIX_BITS-1:0] RADIX_MIN = RADIX_BITS'(2);
   localparam logic [RADIX_BITS-1:0] RADIX_MAX = RADIX_BITS'(16);
   localparam logic [CHAR_BITS-1:0]  CHAR_ZERO = CHAR_BITS'(8'h30);
   localparam logic [CHAR_BITS-1:0]  CHAR_A    = CHAR_BITS'(8'h41);
   localparam logic [DIGIT_BITS-1:0] DIGIT_TEN = DIGIT_BITS'(10);

   // stack control from the sequencer
   typedef struct packed {
      logic clear;
      logic push;
      logic pop;
   } stk_ctrl_type;

   // divider status back to the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   // digit value to uppercase ASCII
   function automatic logic [CHAR_BITS-1:0] glyph(input logic [DIGIT_BITS-1:0] d);
      logic [CHAR_BITS-1:0] c;
      if (d < DIGIT_TEN) begin
         c = CHAR_ZERO + CHAR_BITS'(d);
      end else begin
         c = CHAR_A + CHAR_BITS'(d - DIGIT_TEN);
      end
      return c;
   endfunction

endpackage

>>> rtl/rdc_divider.sv
// Bit-serial restoring divider: one quotient bit per cycle, narrow remainder.
`timescale 1ns / 1ps
module rdc_divider (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [rdc_pkg::DIV_BITS-1:0]     dividend,
   input  logic [rdc_pkg::RADIX_BITS-1:0]   radix,
   output rdc_pkg::div_stat_type            status,
   output logic [rdc_pkg::DIV_BITS-1:0]     quotient,
   output logic [rdc_pkg::DIGIT_BITS-1:0]   remainder
);
   import rdc_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic [DIV_BITS-1:0]   quo_ff, quo_in;
   logic [REM_BITS-1:0]   rem_ff, rem_in;
   logic [RADIX_BITS-1:0] radix_ff, radix_in;
   logic [REM_BITS-1:0]   trial;
   logic                  fits;

   // remainder stays below 16, so the shifted trial fits in five bits
   assign trial = {rem_ff[REM_BITS-2:0], quo_ff[DIV_BITS-1]};
   assign fits  = (trial >= REM_BITS'(radix_ff));

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      step_in  = step_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      radix_in = radix_ff;
      if (start) begin
         busy_in  = 1'b1;
         step_in  = STEP_BITS'(DIV_BITS - 1);
         quo_in   = dividend;
         rem_in   = '0;
         radix_in = radix;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIV_BITS-2:0], fits};
         rem_in = fits ? (trial - REM_BITS'(radix_ff)) : trial;
         step_in = step_ff - STEP_BITS'(1);
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff  <= step_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      radix_ff <= radix_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;
   assign remainder   = rem_ff[DIGIT_BITS-1:0];

`ifndef NO_ASSERTIONS
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff) else $error("divider restarted while busy");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("divider done while still busy");
   a_finish: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && step_ff == '0 && !start) |=> done_ff) else $error("divider missed done");
`endif

endmodule

>>> rtl/rdc_digit_stack.sv
// Digit stack: remainders pushed least significant first, popped most significant first.
`timescale 1ns / 1ps
module rdc_digit_stack (
   input  logic                             clock,
   input  logic                             reset,
   input  rdc_pkg::stk_ctrl_type            ctrl,
   input  logic [rdc_pkg::DIGIT_BITS-1:0]   push_digit,
   output logic [rdc_pkg::DIGIT_BITS-1:0]   top_digit,
   output logic [rdc_pkg::LEVEL_BITS-1:0]   level,
   output logic                             near_full
);
   import rdc_pkg::*;

   logic [DIGIT_BITS-1:0] store_ff [DIGIT_DEPTH];
   logic [LEVEL_BITS-1:0] level_ff, level_in;
   logic [LEVEL_BITS-1:0] top_pos;

   assign top_pos = level_ff - LEVEL_BITS'(1);

   always_comb begin
      level_in = level_ff;
      if (ctrl.clear) begin
         level_in = '0;
      end else if (ctrl.push) begin
         level_in = level_ff + LEVEL_BITS'(1);
      end else if (ctrl.pop) begin
         level_in = top_pos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
      end else begin
         level_ff <= level_in;
      end
      if (ctrl.push && !ctrl.clear) begin
         store_ff[level_ff[INDEX_BITS-1:0]] <= push_digit;
      end
   end

   assign top_digit = store_ff[top_pos[INDEX_BITS-1:0]];
   assign level     = level_ff;
   assign near_full = (level_ff == LEVEL_BITS'(DIGIT_DEPTH - 1));

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      ctrl.push |-> level_ff < LEVEL_BITS'(DIGIT_DEPTH)) else $error("digit stack overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      ctrl.pop |-> level_ff != '0) else $error("digit stack underflow");
   a_one_op: assert property (@(posedge clock) disable iff (reset)
      !(ctrl.push && ctrl.pop)) else $error("push and pop together");
`endif

endmodule

>>> rtl/radix_digit_converter.sv
// Top level: integer to uppercase radix digits, stream in, one character per beat out.
`timescale 1ns / 1ps
// Takes one beat holding a signed value and a base, and returns its digits in that base as
// uppercase ASCII characters, most significant first, tlast on the final one. A base outside
// 2..16 returns a single beat with the bad-radix flag; a value of zero or below returns a
// single beat with the empty flag; both carry character 0. A positive value is divided
// repeatedly by the base in a bit-serial divider that resolves one quotient bit per cycle;
// remainders are stacked and then played out one per cycle while the output register is
// drained. The block takes one item at a time: a new beat is accepted only once the last
// character of the previous one has entered the output register and that register is
// empty or being drained.
module radix_digit_converter (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [31:0] value (signed), [36:32] radix, [39:37] zero
   input  logic [rdc_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [6:0] digit_char, [7] zero
   output logic [rdc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // [0] empty_res, [1] bad_radix
   output logic [rdc_pkg::RSP_USER_W-1:0]   rsp_tuser,
   output logic                             rsp_tlast
);
   import rdc_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_DIVIDE = 3'b010,
      ST_EMIT   = 3'b100
   } state_type;

   state_type             state_ff, state_in;
   logic [RADIX_BITS-1:0] radix_ff, radix_in;

   // output register
   logic                  out_valid_ff, out_valid_in;
   logic [CHAR_BITS-1:0]  out_char_ff, out_char_in;
   logic                  out_empty_ff, out_empty_in;
   logic                  out_bad_ff, out_bad_in;
   logic                  out_last_ff, out_last_in;

   logic [VALUE_BITS-1:0] in_value;
   logic [RADIX_BITS-1:0] in_radix;
   logic                  in_accept;
   logic                  slot_free;
   logic                  radix_bad;
   logic                  value_empty;

   stk_ctrl_type          stk_ctrl;
   logic [DIGIT_BITS-1:0] stk_top;
   logic [LEVEL_BITS-1:0] stk_level;
   logic                  stk_near_full;

   div_stat_type          div_stat;
   logic                  div_start;
   logic [DIV_BITS-1:0]   div_dividend;
   logic [RADIX_BITS-1:0] div_radix;
   logic [DIV_BITS-1:0]   div_quo;
   logic [DIGIT_BITS-1:0] div_rem;

   assign in_value    = req_tdata[VALUE_BITS-1:0];
   assign in_radix    = req_tdata[VALUE_BITS+RADIX_BITS-1:VALUE_BITS];
   assign slot_free   = !out_valid_ff || rsp_tready;
   assign req_tready  = (state_ff == ST_IDLE) && slot_free;
   assign in_accept   = req_tvalid && req_tready;
   assign radix_bad   = (in_radix < RADIX_MIN) || (in_radix > RADIX_MAX);
   assign value_empty = in_value[VALUE_BITS-1] || (in_value == '0);

   always_comb begin
      state_in     = state_ff;
      radix_in     = radix_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_char_in  = out_char_ff;
      out_empty_in = out_empty_ff;
      out_bad_in   = out_bad_ff;
      out_last_in  = out_last_ff;
      stk_ctrl     = '0;
      div_start    = 1'b0;
      div_dividend = div_quo;
      div_radix    = radix_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (in_accept) begin
               if (radix_bad || value_empty) begin
                  // flagged result, bad base wins over the value check
                  out_valid_in = 1'b1;
                  out_char_in  = '0;
                  out_empty_in = !radix_bad;
                  out_bad_in   = radix_bad;
                  out_last_in  = 1'b1;
               end else begin
                  radix_in       = in_radix;
                  stk_ctrl.clear = 1'b1;
                  div_start      = 1'b1;
                  div_dividend   = in_value[DIV_BITS-1:0];
                  div_radix      = in_radix;
                  state_in       = ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            if (div_stat.done) begin
               stk_ctrl.push = 1'b1;
               if (div_quo == '0 || stk_near_full) begin
                  state_in = ST_EMIT;
               end else begin
                  div_start = 1'b1;
               end
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               stk_ctrl.pop = 1'b1;
               out_valid_in = 1'b1;
               out_char_in  = glyph(stk_top);
               out_empty_in = 1'b0;
               out_bad_in   = 1'b0;
               out_last_in  = (stk_level == LEVEL_BITS'(1));
               if (stk_level == LEVEL_BITS'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      radix_ff     <= radix_in;
      out_char_ff  <= out_char_in;
      out_empty_ff <= out_empty_in;
      out_bad_ff   <= out_bad_in;
      out_last_ff  <= out_last_in;
   end

   rdc_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .radix     (div_radix),
      .status    (div_stat),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   rdc_digit_stack u_stack (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (stk_ctrl),
      .push_digit (div_rem),
      .top_digit  (stk_top),
      .level      (stk_level),
      .near_full  (stk_near_full)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - CHAR_BITS)'(0), out_char_ff};
   assign rsp_tuser  = {out_bad_ff, out_empty_ff};
   assign rsp_tlast  = out_last_ff;

`ifndef NO_ASSERTIONS
   a_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> state_ff == ST_DIVIDE) else $error("division finished outside a conversion");
   a_flag_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (out_empty_ff || out_bad_ff)) |-> (rsp_tlast && out_char_ff == '0))
      else $error("flagged beat not a single last beat");
   a_emit_has_digits: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> stk_level != '0) else $error("emitting from an empty stack");
   a_divide_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE && !div_stat.done) |-> div_stat.busy)
      else $error("divider stalled mid conversion");
`endif

endmodule
